// ===== hw/rtl/ilst_pkg.sv =====
// ilst_pkg: opcodes, status codes, cell control word and tree sizing for the
// indexed list shift table. No dependencies; imported by every ilst module.
package ilst_pkg;

    typedef enum logic [2:0] {
        OP_APPEND    = 3'd0,
        OP_INSERT    = 3'd1,
        OP_REMOVE    = 3'd2,
        OP_OVERWRITE = 3'd3,
        OP_READ      = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        STS_DONE  = 2'd0,
        STS_FULL  = 2'd1,
        STS_RANGE = 2'd2
    } sts_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_REMOVE,
        CELL_WRITE
    } cell_op_t;

    typedef struct packed {
        cell_op_t    kind;
        logic        capture;
        logic [31:0] value;
    } cell_ctl_t;

    typedef enum logic {
        ST_IDLE,
        ST_BUSY
    } state_t;

    localparam int TREE_FANIN = 32;

    function automatic int tree_levels(input int n);
        int lv;
        int span;
        lv = 1;
        span = TREE_FANIN;
        while (span < n) begin
            span = span * TREE_FANIN;
            lv = lv + 1;
        end
        return lv;
    endfunction

endpackage

// ===== hw/rtl/indexed_list_shift_table.sv =====
// indexed_list_shift_table: top level. Row of ilst_cell entries plus the
// ilst_rdtree read gather and the request/result control. Uses ilst_pkg.
//
// Usage:
//   Slave channel s_*: one word per request. s_tdata holds opcode [2:0],
//   position [12:3], item_value [44:13], zero padded to 48 bits.
//   Master channel m_*: one word per request. m_tdata holds read_value
//   [31:0], item_count [42:32], status [44:43], zero padded to 48 bits.
//   The whole row of cells shifts, writes and taps at the edge that accepts
//   a request. The read value is gathered through a registered OR tree of
//   tree_levels(CAPACITY) stages (2 at CAPACITY 1024). The result is loaded
//   into the result register once it leaves the tree and that register is
//   free; only then is the next request taken, so requests do not overlap.
//   The result register is separate from the request side: a request can be
//   accepted while the previous result waits; its result then waits in turn
//   until m_tready takes the held word.
//   Reset (aresetn low, synchronous) empties the list and drops any pending
//   result; entry contents are not cleared.
module indexed_list_shift_table
    import ilst_pkg::*;
#(
    parameter int CAPACITY = 1024
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // opcode, position, item_value
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata    // read_value, item_count, status
);

    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int CMP_W  = (CNT_W > 10) ? CNT_W : 10;
    localparam int LEVELS = tree_levels(CAPACITY);
    localparam int WAIT_W = $clog2(LEVELS + 1);

    op_t              op;
    logic [9:0]       pos_in;
    logic [31:0]      val_in;
    logic [CMP_W-1:0] posc;
    logic [CMP_W-1:0] cntc;
    logic             full;
    logic             s_accept;

    cell_ctl_t        ctl;
    logic [CMP_W-1:0] cell_pos;
    sts_t             sts;
    logic             rd_en;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;

    state_t           state_reg;
    state_t           state_next;
    logic [WAIT_W-1:0] wait_reg;
    logic [WAIT_W-1:0] wait_next;
    logic             load_out;

    sts_t             sts_pend_reg;
    logic             rd_pend_reg;
    logic [CNT_W-1:0] cnt_pend_reg;

    logic             m_tvalid_reg;
    logic [31:0]      out_value_reg;
    logic [10:0]      out_count_reg;
    sts_t             out_status_reg;

    logic [31:0]      cell_value [CAPACITY];
    logic [31:0]      cell_tap   [CAPACITY];
    logic [31:0]      tree_result;

    assign op       = op_t'(s_tdata[2:0]);
    assign pos_in   = s_tdata[12:3];
    assign val_in   = s_tdata[44:13];
    assign posc     = CMP_W'(pos_in);
    assign cntc     = CMP_W'(cnt_reg);
    assign full     = (cnt_reg == CNT_W'(CAPACITY));
    assign s_accept = s_tvalid && s_tready;

    always_comb begin
        ctl.kind    = CELL_HOLD;
        ctl.capture = s_accept;
        ctl.value   = val_in;
        cell_pos    = posc;
        sts         = STS_DONE;
        rd_en       = 1'b0;
        cnt_next    = cnt_reg;
        unique case (op)
            OP_APPEND: begin
                if (full) begin
                    sts = STS_FULL;
                end else begin
                    ctl.kind = CELL_WRITE;
                    cell_pos = cntc;
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            OP_INSERT: begin
                if (full) begin
                    sts = STS_FULL;
                end else if (posc > cntc) begin
                    sts = STS_RANGE;
                end else begin
                    ctl.kind = CELL_INSERT;
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            OP_REMOVE: begin
                if (posc >= cntc) begin
                    sts = STS_RANGE;
                end else begin
                    ctl.kind = CELL_REMOVE;
                    rd_en    = 1'b1;
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            OP_OVERWRITE: begin
                if (posc >= cntc) begin
                    sts = STS_RANGE;
                end else begin
                    ctl.kind = CELL_WRITE;
                end
            end
            OP_READ: begin
                if (posc >= cntc) begin
                    sts = STS_RANGE;
                end else begin
                    rd_en = 1'b1;
                end
            end
            default: begin
            end
        endcase
        if (!s_accept) begin
            ctl.kind = CELL_HOLD;
        end
    end

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic [31:0] left_value;
        logic [31:0] right_value;
        if (i == 0) begin : g_first
            assign left_value = '0;
        end else begin : g_mid_l
            assign left_value = cell_value[i - 1];
        end
        if (i == CAPACITY - 1) begin : g_last
            assign right_value = '0;
        end else begin : g_mid_r
            assign right_value = cell_value[i + 1];
        end
        ilst_cell #(
            .CMP_W (CMP_W)
        ) u_cell (
            .aclk        (aclk),
            .ctl         (ctl),
            .pos         (cell_pos),
            .idx         (CMP_W'(i)),
            .left_value  (left_value),
            .right_value (right_value),
            .value       (cell_value[i]),
            .tap         (cell_tap[i])
        );
    end

    ilst_rdtree #(
        .LEAVES (CAPACITY),
        .LEVELS (LEVELS)
    ) u_rdtree (
        .aclk   (aclk),
        .leaves (cell_tap),
        .result (tree_result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            wait_reg  <= '0;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            wait_reg  <= wait_next;
            if (s_accept) begin
                cnt_reg <= cnt_next;
            end
        end
    end

    always_comb begin
        state_next = state_reg;
        wait_next  = wait_reg;
        s_tready   = 1'b0;
        load_out   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = aresetn;
                if (s_tvalid) begin
                    state_next = ST_BUSY;
                    wait_next  = WAIT_W'(LEVELS);
                end
            end
            ST_BUSY: begin
                if (wait_reg != '0) begin
                    wait_next = wait_reg - 1'b1;
                end else if (!m_tvalid_reg || m_tready) begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            sts_pend_reg <= sts;
            rd_pend_reg  <= rd_en;
            cnt_pend_reg <= cnt_next;
        end
        if (load_out) begin
            out_value_reg  <= rd_pend_reg ? tree_result : '0;
            out_count_reg  <= 11'(cnt_pend_reg);
            out_status_reg <= sts_pend_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (load_out) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {3'b000, out_status_reg, out_count_reg, out_value_reg};

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(CAPACITY))
        else $error("item count above capacity");

    a_append_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && op == OP_APPEND && !full |=> cnt_reg == $past(cnt_reg) + 1'b1)
        else $error("append did not grow the list");

    a_load_from_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(state_reg) == ST_BUSY)
        else $error("result shown without a request in flight");

    a_range_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[44:43] == STS_RANGE |-> m_tdata[31:0] == '0)
        else $error("out-of-range result carries data");
`endif

endmodule

// ===== hw/rtl/ilst_cell.sv =====
// ilst_cell: one list entry. Shifts with its neighbors on insert/remove,
// takes writes at its own index and taps its value for reads. Uses ilst_pkg.
module ilst_cell
    import ilst_pkg::*;
#(
    parameter int CMP_W = 11
) (
    input  logic             aclk,
    input  cell_ctl_t        ctl,
    input  logic [CMP_W-1:0] pos,
    input  logic [CMP_W-1:0] idx,
    input  logic [31:0]      left_value,
    input  logic [31:0]      right_value,
    output logic [31:0]      value,
    output logic [31:0]      tap
);

    logic [31:0] data_reg;
    logic [31:0] tap_reg;
    logic        at_pos;
    logic        above_pos;

    assign at_pos    = (idx == pos);
    assign above_pos = (idx > pos);

    always_ff @(posedge aclk) begin
        case (ctl.kind)
            CELL_INSERT: begin
                if (at_pos) begin
                    data_reg <= ctl.value;
                end else if (above_pos) begin
                    data_reg <= left_value;
                end
            end
            CELL_REMOVE: begin
                if (at_pos || above_pos) begin
                    data_reg <= right_value;
                end
            end
            CELL_WRITE: begin
                if (at_pos) begin
                    data_reg <= ctl.value;
                end
            end
            default: begin
            end
        endcase
        if (ctl.capture) begin
            tap_reg <= at_pos ? data_reg : '0;
        end
    end

    assign value = data_reg;
    assign tap   = tap_reg;

endmodule

// ===== hw/rtl/ilst_rdtree.sv =====
// ilst_rdtree: registered OR tree that gathers the one nonzero cell tap.
// Uses ilst_pkg for the fan-in.
module ilst_rdtree
    import ilst_pkg::*;
#(
    parameter int LEAVES = 1024,
    parameter int LEVELS = 2
) (
    input  logic        aclk,
    input  logic [31:0] leaves [LEAVES],
    output logic [31:0] result
);

    logic [31:0] tree_reg [LEVELS][LEAVES];

    always_ff @(posedge aclk) begin
        logic [31:0] acc;
        for (int k = 0; k < LEVELS; k++) begin
            for (int j = 0; j < LEAVES; j++) begin
                acc = '0;
                for (int m = 0; m < TREE_FANIN; m++) begin
                    if (j * TREE_FANIN + m < LEAVES) begin
                        if (k == 0) begin
                            acc = acc | leaves[j * TREE_FANIN + m];
                        end else begin
                            acc = acc | tree_reg[k - 1][j * TREE_FANIN + m];
                        end
                    end
                end
                tree_reg[k][j] <= acc;
            end
        end
    end

    assign result = tree_reg[LEVELS - 1][0];

endmodule
